// ===== src/kwrm_pkg.sv =====
// Shared types, codes and the entry ordering of the run-merge heap.
package kwrm_pkg;

   localparam int KEY_W      = 64;
   localparam int RUN_W      = 4;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int HEADS_W    = 5;
   localparam int REQ_DATA_W = 72;   // key, run, zero fill
   localparam int RSP_DATA_W = 80;   // key, run, heads, zero fill
   localparam int RSP_USER_W = 3;    // out_valid, status
   localparam int RSP_PAD_W  = RSP_DATA_W - KEY_W - RUN_W - HEADS_W;

   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [RUN_W-1:0] run;
   } entry_type;

   // Total order: key first, then run number, lowest first.
   function automatic logic ent_less(entry_type a, entry_type b);
      logic lt;
      if (a.key != b.key) begin
         lt = (a.key < b.key);
      end else begin
         lt = (a.run < b.run);
      end
      return lt;
   endfunction

endpackage

// ===== src/kwrm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module kwrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/k_way_run_merge_heap.sv =====
// Top level of the run-merge heap: min-heap of run heads held in one entry RAM.
//
// Merge stage of an external sort. Each request beat on req_ carries one operation in
// req_tuser (insert a run head, extract the minimum, or extract and replace it with the
// run's next key) and the entering key and run in req_tdata. Every request gives exactly
// one response beat on rsp_: the removed key and run, a flag that they are valid, a
// status (ok, insert into full heap ignored, extract from empty heap) and the number
// of heads still held. Equal keys leave lowest run first.
// Heap entries live in one RAM with a single read and a single write port; an insert
// climbs from the new leaf, while an extract or replace fetches the root first (an
// extract of more than one head then fetches the last one), and the held entry sifts
// through the levels as a hole. One operation at a time: an insert reads the parent and
// compares it on each level climbed; each level descended reads the left and then the
// right child (the right only where one exists), compares the smaller with the held
// entry and writes. The response beat appears in the same cycle that the next request
// can be taken; if the receiver stalls, that beat holds and the next operation waits
// after its work until the output register frees.
// Reset empties the heap at once; no clearing pass runs.
module k_way_run_merge_heap
   import kwrm_pkg::*;
#(
   parameter int RUNS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key_value[63:0], run_id[67:64], zero
   input  logic [FUNC_W-1:0]     req_tuser,   // func[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_key[63:0], out_run[67:64],
                                              // heads_left[72:68], zero
   output logic [RSP_USER_W-1:0] rsp_tuser    // out_valid[0], status[2:1]
);

   localparam int AW = $clog2(RUNS);
   localparam int CW = $clog2(RUNS + 1);
   localparam int IW = AW + 2;
   localparam int EW = $bits(entry_type);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UP_CHK = 4'd1;
   localparam logic [3:0] S_UP_CMP = 4'd2;
   localparam logic [3:0] S_ROOT   = 4'd3;
   localparam logic [3:0] S_LAST   = 4'd4;
   localparam logic [3:0] S_DN_L   = 4'd5;
   localparam logic [3:0] S_DN_R   = 4'd6;
   localparam logic [3:0] S_DN_RC  = 4'd7;
   localparam logic [3:0] S_DN_CMP = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [AW-1:0]       idx_ff, idx_in;
   entry_type           ent_ff, ent_in;
   entry_type           best_ff, best_in;
   logic                repl_ff, repl_in;
   logic [KEY_W-1:0]    okey_ff, okey_in;
   logic [RUN_W-1:0]    orun_ff, orun_in;
   logic                oval_ff, oval_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;

   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                  rsp_load;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_ent;
   logic [AW-1:0]   rd_addr;
   logic [EW-1:0]   rd_raw;
   entry_type       rd_ent;

   logic [IW-1:0]   lft;
   logic [IW-1:0]   rgt;
   logic [IW-1:0]   cnt_w;
   logic [AW-1:0]   par;

   kwrm_ram #(
      .WIDTH (EW),
      .DEPTH (RUNS)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent = entry_type'(rd_raw);
   assign lft    = {1'b0, pos_ff, 1'b1};
   assign rgt    = lft + IW'(1);
   assign cnt_w  = IW'(count_ff);
   assign par    = AW'((pos_ff - AW'(1)) >> 1);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      ent_in   = ent_ff;
      best_in  = best_ff;
      repl_in  = repl_ff;
      okey_in  = okey_ff;
      orun_in  = orun_ff;
      oval_in  = oval_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_ent   = ent_ff;
      rd_addr  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ent_in.key = req_tdata[KEY_W-1:0];
               ent_in.run = req_tdata[KEY_W+RUN_W-1:KEY_W];
               repl_in    = (req_tuser == FUNC_REPLACE);
               okey_in    = '0;
               orun_in    = '0;
               oval_in    = 1'b0;
               stat_in    = ST_OK;
               case (req_tuser)
                  FUNC_INSERT: begin
                     if (count_ff == CW'(RUNS)) begin
                        stat_in  = ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        pos_in   = AW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_CHK;
                     end
                  end
                  FUNC_EXTRACT, FUNC_REPLACE: begin
                     if (count_ff == '0) begin
                        stat_in  = ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        rd_addr  = '0;
                        state_in = S_ROOT;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = par;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (ent_less(ent_ff, rd_ent)) begin
               // pull the parent down into the hole and climb
               wr_ent   = rd_ent;
               pos_in   = par;
               state_in = S_UP_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ROOT: begin
            okey_in = rd_ent.key;
            orun_in = rd_ent.run;
            oval_in = 1'b1;
            pos_in  = '0;
            if (repl_ff) begin
               state_in = S_DN_L;
            end else begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = S_DONE;
               end else begin
                  rd_addr  = AW'(count_ff - CW'(1));
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            ent_in   = rd_ent;
            state_in = S_DN_L;
         end
         S_DN_L: begin
            if (lft >= cnt_w) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = lft[AW-1:0];
               state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            best_in = rd_ent;
            idx_in  = lft[AW-1:0];
            if (rgt < cnt_w) begin
               rd_addr  = rgt[AW-1:0];
               state_in = S_DN_RC;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_RC: begin
            if (ent_less(rd_ent, best_ff)) begin
               best_in = rd_ent;
               idx_in  = rgt[AW-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (ent_less(best_ff, ent_ff)) begin
               // lift the smaller child into the hole and descend
               wr_ent   = best_ff;
               pos_in   = idx_ff;
               state_in = S_DN_L;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      ent_ff  <= ent_in;
      best_ff <= best_in;
      repl_ff <= repl_in;
      okey_ff <= okey_in;
      orun_ff <= orun_in;
      oval_ff <= oval_in;
      stat_ff <= stat_in;
      if (rsp_load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, HEADS_W'(count_ff), orun_ff, okey_ff};
         rsp_user_ff <= {stat_ff, oval_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RUNS))
      else $error("heap count above capacity");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (IW'(wr_addr) < cnt_w))
      else $error("heap write outside the held entries");

   a_root_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (count_ff != '0))
      else $error("root fetched from an empty heap");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("response loaded outside the done state");

   a_valid_means_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_user_ff[0]) |-> (rsp_user_ff[2:1] == ST_OK))
      else $error("removed entry reported with an error status");

endmodule
